// ----- src/sgrm_pkg.sv -----
// ----------------------------------------------------------------------------
// sgrm_pkg
// Shared types, constants and arithmetic helpers of the spectral gain mixer.
// ----------------------------------------------------------------------------
package sgrm_pkg;

    localparam int HALF_BINS  = 1024;
    localparam int IDX_W      = $clog2(HALF_BINS);
    localparam int Q_ONE      = 65536;
    localparam int PEAK_FLOOR = 1311;
    localparam int CFG_W      = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int QDEPTH     = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE,
        CFG_RES_ONLY,
        CFG_WHITENING,
        CFG_REDUCTION,
        CFG_PEAK_DECAY,
        CFG_SMOOTHING
    } t_cfg_idx;

    typedef struct packed {
        logic        enable;
        logic        res_only;
        logic [16:0] wamt;
        logic [16:0] red;
        logic [15:0] decay;
        logic [16:0] srate;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] bin;
        logic [16:0]        gain;
        logic               active;
        logic               last;
    } t_item;

    typedef struct packed {
        logic clearing;
    } t_bk_status;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_MIX, S_MIXU, S_DEN, S_RES, S_PEAK, S_DIV,
        S_WB1, S_WB2, S_FIN1, S_FIN2, S_X1, S_X2, S_OUT
    } t_state;

    typedef logic signed [50:0] t_prod;

    function automatic logic [16:0] clamp_one(input logic [16:0] v);
        return (v > 17'(Q_ONE)) ? 17'(Q_ONE) : v;
    endfunction

    // round half up at bit 16, then saturate to 32 bits
    function automatic logic signed [31:0] rnd_sat(input logic signed [51:0] p);
        logic signed [51:0] s;
        s = (p + 52'sd32768) >>> 16;
        if (s > 52'sd2147483647)
            return 32'sh7FFFFFFF;
        if (s < -52'sd2147483648)
            return 32'sh80000000;
        return s[31:0];
    endfunction

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v > 33'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -33'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

endpackage

// ----- src/sgrm_ram.sv -----
// ----------------------------------------------------------------------------
// sgrm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sgrm_ram #(
    parameter int W = 32,
    parameter int D = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/sgrm_front.sv -----
// ----------------------------------------------------------------------------
// sgrm_front
// Input side: takes requests, clamps the gain and queues them for the back end.
// ----------------------------------------------------------------------------
module sgrm_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic signed [31:0]      i_bin_value,
    input  logic [16:0]             i_bin_gain,
    input  logic                    i_frame_active,
    input  logic                    i_last_bin,
    input  sgrm_pkg::t_bk_status    i_status,
    output logic                    o_q_valid,
    output sgrm_pkg::t_item         o_q_item,
    input  logic                    i_q_pop
);

    sgrm_pkg::t_item r_q [sgrm_pkg::QDEPTH];
    logic            r_wp, n_wp;
    logic            r_rp, n_rp;
    logic [1:0]      r_cnt, n_cnt;
    logic            w_push;
    sgrm_pkg::t_item w_item;

    assign o_in_stall = (r_cnt == 2'(sgrm_pkg::QDEPTH)) || i_status.clearing;
    assign w_push     = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_item   = r_q[r_rp];

    always_comb begin
        w_item.bin    = i_bin_value;
        w_item.gain   = sgrm_pkg::clamp_one(i_bin_gain);
        w_item.active = i_frame_active;
        w_item.last   = i_last_bin;
        n_wp  = w_push  ? ~r_wp : r_wp;
        n_rp  = i_q_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + 2'(w_push) - 2'(i_q_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

endmodule

// ----- src/sgrm_back.sv -----
// ----------------------------------------------------------------------------
// sgrm_back
// Per-bin datapath: gain split, peak tracking, whitening divide, final mix
// and wet/dry cross-fade, sequenced over two shared multipliers.
// ----------------------------------------------------------------------------
module sgrm_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  sgrm_pkg::t_cfg          i_cfg,
    input  logic                    i_q_valid,
    input  sgrm_pkg::t_item         i_q_item,
    output logic                    o_q_pop,
    output sgrm_pkg::t_bk_status    o_status,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [31:0]      o_out_value,
    output logic                    o_out_last
);

    sgrm_pkg::t_state r_state, n_state;

    logic [sgrm_pkg::IDX_W-1:0] r_clr;
    logic [sgrm_pkg::IDX_W-1:0] r_idx;
    sgrm_pkg::t_item            r_item;
    logic [16:0]                r_mix;
    logic                       r_started;
    logic signed [31:0]         r_peak_rd, r_proc_rd;
    logic signed [50:0]         r_pa, r_pb;
    logic signed [31:0]         r_den, r_res, r_dec, r_peak, r_fin, r_result;
    logic [47:0]                r_rem;
    logic [16:0]                r_quo;
    logic [4:0]                 r_cnt;
    logic                       r_ov, r_olast;
    logic signed [31:0]         r_oval;

    logic signed [32:0] w_ma, w_mc;
    logic signed [17:0] w_mb, w_md;
    sgrm_pkg::t_prod    w_prod_a, w_prod_b;

    logic                       w_peak_we, w_proc_we;
    logic [sgrm_pkg::IDX_W-1:0] w_waddr;
    logic signed [31:0]         w_peak_wd, w_proc_wd;
    logic [31:0]                w_peak_rdata, w_proc_rdata;

    logic                       w_out_free;
    logic                       w_white;
    logic                       w_frame_end;
    logic signed [31:0]         w_peak;
    logic signed [31:0]         w_proc;
    logic [47:0]                w_trial;
    logic signed [17:0]         w_mix_diff;
    logic signed [32:0]         w_mix_sum;

    assign w_out_free  = !r_ov || !i_out_stall;
    assign w_white     = (i_cfg.wamt != 17'd0);
    assign w_frame_end = r_item.last || (r_idx == sgrm_pkg::IDX_W'(sgrm_pkg::HALF_BINS - 1));
    assign w_proc      = r_item.active ? r_fin : r_proc_rd;
    assign w_trial     = 48'($unsigned(r_peak)) << r_cnt;
    assign w_mix_diff  = (i_cfg.enable ? 18'sd65536 : 18'sd0) - $signed({1'b0, r_mix});
    assign w_mix_sum   = $signed({16'd0, r_mix}) + 33'(sgrm_pkg::rnd_sat(52'(r_pa)));

    always_comb begin
        if (r_res > 32'sd1311)
            w_peak = r_res;
        else
            w_peak = 32'(sgrm_pkg::PEAK_FLOOR);
        if (r_started && (r_dec > w_peak))
            w_peak = r_dec;
    end

    assign w_prod_a = w_ma * w_mb;
    assign w_prod_b = w_mc * w_md;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sgrm_pkg::S_CLR: begin
                if (r_clr == sgrm_pkg::IDX_W'(sgrm_pkg::HALF_BINS - 1))
                    n_state = sgrm_pkg::S_IDLE;
            end
            sgrm_pkg::S_IDLE: if (i_q_valid) n_state = sgrm_pkg::S_MIX;
            sgrm_pkg::S_MIX:  n_state = sgrm_pkg::S_MIXU;
            sgrm_pkg::S_MIXU: n_state = sgrm_pkg::S_DEN;
            sgrm_pkg::S_DEN:  n_state = sgrm_pkg::S_RES;
            sgrm_pkg::S_RES:  n_state = sgrm_pkg::S_PEAK;
            sgrm_pkg::S_PEAK: begin
                if (!r_item.active)
                    n_state = sgrm_pkg::S_X1;
                else if (w_white && (r_res > 32'sd0))
                    n_state = sgrm_pkg::S_DIV;
                else
                    n_state = sgrm_pkg::S_FIN1;
            end
            sgrm_pkg::S_DIV:  if (r_cnt == 5'd0) n_state = sgrm_pkg::S_WB1;
            sgrm_pkg::S_WB1:  n_state = sgrm_pkg::S_WB2;
            sgrm_pkg::S_WB2:  n_state = sgrm_pkg::S_FIN1;
            sgrm_pkg::S_FIN1: n_state = sgrm_pkg::S_FIN2;
            sgrm_pkg::S_FIN2: n_state = sgrm_pkg::S_X1;
            sgrm_pkg::S_X1:   n_state = sgrm_pkg::S_X2;
            sgrm_pkg::S_X2:   n_state = sgrm_pkg::S_OUT;
            sgrm_pkg::S_OUT:  if (w_out_free) n_state = sgrm_pkg::S_IDLE;
            default: n_state = sgrm_pkg::S_CLR;
        endcase
    end

    // outputs: multiplier operands, memory writes, queue pop
    always_comb begin
        w_ma      = '0;
        w_mb      = '0;
        w_mc      = '0;
        w_md      = '0;
        w_peak_we = 1'b0;
        w_proc_we = 1'b0;
        w_waddr   = r_idx;
        w_peak_wd = w_peak;
        w_proc_wd = r_result;
        o_q_pop   = 1'b0;
        unique case (r_state)
            sgrm_pkg::S_CLR: begin
                w_peak_we = 1'b1;
                w_proc_we = 1'b1;
                w_waddr   = r_clr;
                w_peak_wd = '0;
                w_proc_wd = '0;
            end
            sgrm_pkg::S_IDLE: o_q_pop = i_q_valid;
            sgrm_pkg::S_MIX: begin
                w_ma = 33'(w_mix_diff);
                w_mb = $signed({1'b0, i_cfg.srate});
            end
            sgrm_pkg::S_MIXU: begin
                w_ma = 33'(r_item.bin);
                w_mb = $signed({1'b0, r_item.gain});
            end
            sgrm_pkg::S_DEN: begin
                w_mc = 33'(r_peak_rd);
                w_md = $signed({2'b0, i_cfg.decay});
            end
            sgrm_pkg::S_PEAK: w_peak_we = r_item.active && w_white;
            sgrm_pkg::S_WB1: begin
                w_ma = 33'(r_res);
                w_mb = $signed({1'b0, 17'(sgrm_pkg::Q_ONE) - i_cfg.wamt});
                w_mc = $signed({16'd0, r_quo});
                w_md = $signed({1'b0, i_cfg.wamt});
            end
            sgrm_pkg::S_FIN1: begin
                w_ma = 33'(r_res);
                w_mb = $signed({1'b0, i_cfg.red});
            end
            sgrm_pkg::S_X1: begin
                w_ma = 33'(r_item.bin);
                w_mb = $signed({1'b0, 17'(sgrm_pkg::Q_ONE) - r_mix});
                w_mc = 33'(w_proc);
                w_md = $signed({1'b0, r_mix});
            end
            sgrm_pkg::S_OUT: w_proc_we = w_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sgrm_pkg::S_CLR;
            r_clr     <= '0;
            r_idx     <= '0;
            r_mix     <= '0;
            r_started <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == sgrm_pkg::S_CLR)
                r_clr <= r_clr + sgrm_pkg::IDX_W'(1);
            if ((r_state == sgrm_pkg::S_MIXU) && (r_idx == '0))
                r_mix <= w_mix_sum[16:0];
            if ((r_state == sgrm_pkg::S_OUT) && w_out_free) begin
                r_ov <= 1'b1;
                if (w_frame_end) begin
                    r_idx <= '0;
                    if (r_item.active && w_white)
                        r_started <= 1'b1;
                end else begin
                    r_idx <= r_idx + sgrm_pkg::IDX_W'(1);
                end
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            sgrm_pkg::S_IDLE: if (i_q_valid) r_item <= i_q_item;
            sgrm_pkg::S_MIX: begin
                r_peak_rd <= $signed(w_peak_rdata);
                r_proc_rd <= $signed(w_proc_rdata);
                r_pa      <= w_prod_a;
            end
            sgrm_pkg::S_MIXU: r_pa <= w_prod_a;
            sgrm_pkg::S_DEN: begin
                r_den <= sgrm_pkg::rnd_sat(52'(r_pa));
                r_pb  <= w_prod_b;
            end
            sgrm_pkg::S_RES: begin
                r_res <= sgrm_pkg::sat33(33'(r_item.bin) - 33'(r_den));
                r_dec <= sgrm_pkg::rnd_sat(52'(r_pb));
            end
            sgrm_pkg::S_PEAK: begin
                r_peak <= w_peak;
                r_rem  <= (48'($unsigned(r_res)) << 16) + 48'($unsigned(w_peak >>> 1));
                r_quo  <= '0;
                r_cnt  <= 5'd16;
            end
            sgrm_pkg::S_DIV: begin
                if (r_rem >= w_trial) begin
                    r_rem <= r_rem - w_trial;
                    r_quo <= {r_quo[15:0], 1'b1};
                end else begin
                    r_quo <= {r_quo[15:0], 1'b0};
                end
                r_cnt <= r_cnt - 5'd1;
            end
            sgrm_pkg::S_WB1: begin
                r_pa <= w_prod_a;
                r_pb <= w_prod_b;
            end
            sgrm_pkg::S_WB2: r_res <= sgrm_pkg::rnd_sat(52'(r_pa) + 52'(r_pb));
            sgrm_pkg::S_FIN1: r_pa <= w_prod_a;
            sgrm_pkg::S_FIN2: begin
                if (i_cfg.res_only)
                    r_fin <= r_res;
                else
                    r_fin <= sgrm_pkg::sat33(33'(r_den) + 33'(sgrm_pkg::rnd_sat(52'(r_pa))));
            end
            sgrm_pkg::S_X1: begin
                r_pa <= w_prod_a;
                r_pb <= w_prod_b;
            end
            sgrm_pkg::S_X2: r_result <= sgrm_pkg::rnd_sat(52'(r_pa) + 52'(r_pb));
            sgrm_pkg::S_OUT: begin
                if (w_out_free) begin
                    r_oval  <= r_result;
                    r_olast <= r_item.last;
                end
            end
            default: ;
        endcase
    end

    sgrm_ram #(.W(32), .D(sgrm_pkg::HALF_BINS)) u_peak_ram (
        .i_clk   (i_clk),
        .i_we    (w_peak_we),
        .i_waddr (w_waddr),
        .i_wdata (w_peak_wd),
        .i_raddr (r_idx),
        .o_rdata (w_peak_rdata)
    );

    sgrm_ram #(.W(32), .D(sgrm_pkg::HALF_BINS)) u_proc_ram (
        .i_clk   (i_clk),
        .i_we    (w_proc_we),
        .i_waddr (w_waddr),
        .i_wdata (w_proc_wd),
        .i_raddr (r_idx),
        .o_rdata (w_proc_rdata)
    );

    assign o_status.clearing = (r_state == sgrm_pkg::S_CLR);
    assign o_out_valid       = r_ov;
    assign o_out_value       = r_oval;
    assign o_out_last        = r_olast;

`ifndef SYNTHESIS
    a_mix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mix <= 17'(sgrm_pkg::Q_ONE))
        else $error("wet/dry factor above unity");

    a_peak_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sgrm_pkg::S_PEAK) && w_peak_we
            |-> w_peak_wd >= 32'(sgrm_pkg::PEAK_FLOOR))
        else $error("peak written below floor");

    a_quo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sgrm_pkg::S_WB1) |-> r_quo <= 17'(sgrm_pkg::Q_ONE))
        else $error("whitening quotient out of range");

    a_no_out_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sgrm_pkg::S_CLR) |-> !r_ov)
        else $error("result presented during clearing pass");
`endif

endmodule

// ----- src/spectral_gain_residual_mixer_core.sv -----
// ----------------------------------------------------------------------------
// spectral_gain_residual_mixer_core
// Residual whitening / noise-reduction mixer with soft wet/dry bypass.
// ----------------------------------------------------------------------------
// One bin is processed at a time by a sequenced datapath with two shared
// multipliers. An active bin runs the gain split, the final mix and the
// cross-fade, a bin of an inactive frame skips the final mix; when whitening
// is on and the residual is positive the restoring divider and the whitening
// blend run before the final mix. A stalled, full output register holds the
// datapath in its output state. A two-entry input queue takes new requests
// while a bin is in work. After reset the per-bin peak and processed stores
// are cleared, one entry per cycle; input is stalled meanwhile, configuration
// writes are taken. Configuration is to be written only while the block is idle.
module spectral_gain_residual_mixer_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic signed [31:0]              i_bin_value,
    input  logic [16:0]                     i_bin_gain,
    input  logic                            i_frame_active,
    input  logic                            i_last_bin,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic signed [31:0]              o_out_value,
    output logic                            o_out_last,
    input  logic                            i_cfg_we,
    input  logic [sgrm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sgrm_pkg::CFG_W-1:0]      i_cfg_wdata
);

    sgrm_pkg::t_cfg       r_cfg;
    sgrm_pkg::t_bk_status w_status;
    sgrm_pkg::t_item      w_q_item;
    logic                 w_q_valid, w_q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable   <= 1'b0;
            r_cfg.res_only <= 1'b0;
            r_cfg.wamt     <= 17'd0;
            r_cfg.red      <= 17'd65536;
            r_cfg.decay    <= 16'd65000;
            r_cfg.srate    <= 17'd2048;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sgrm_pkg::CFG_ENABLE:     r_cfg.enable   <= i_cfg_wdata[0];
                sgrm_pkg::CFG_RES_ONLY:   r_cfg.res_only <= i_cfg_wdata[0];
                sgrm_pkg::CFG_WHITENING:  r_cfg.wamt  <= sgrm_pkg::clamp_one(i_cfg_wdata);
                sgrm_pkg::CFG_REDUCTION:  r_cfg.red   <= sgrm_pkg::clamp_one(i_cfg_wdata);
                sgrm_pkg::CFG_PEAK_DECAY: r_cfg.decay <= i_cfg_wdata[15:0];
                sgrm_pkg::CFG_SMOOTHING:  r_cfg.srate <= sgrm_pkg::clamp_one(i_cfg_wdata);
                default: ;
            endcase
        end
    end

    sgrm_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_bin_value    (i_bin_value),
        .i_bin_gain     (i_bin_gain),
        .i_frame_active (i_frame_active),
        .i_last_bin     (i_last_bin),
        .i_status       (w_status),
        .o_q_valid      (w_q_valid),
        .o_q_item       (w_q_item),
        .i_q_pop        (w_q_pop)
    );

    sgrm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .o_q_pop     (w_q_pop),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_value (o_out_value),
        .o_out_last  (o_out_last)
    );

endmodule

// ----- tb/spectral_gain_residual_mixer_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectral_gain_residual_mixer_core_tb
// Self-checking bench for the spectral gain / residual mixer. A queue of
// frames feeds a bursty request driver, a bit-exact predictor tracks peaks,
// processed bins and the wet/dry factor, and a monitor with its own stall
// pattern checks every output bin in order.
// ----------------------------------------------------------------------------
module spectral_gain_residual_mixer_core_tb;

    localparam logic [sgrm_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = '1;

    typedef struct {
        logic signed [31:0] value;
        logic               last;
    } t_out_bin;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_stall;
    logic signed [31:0]             i_bin_value = '0;
    logic [16:0]                    i_bin_gain = '0;
    logic                           i_frame_active = 1'b0;
    logic                           i_last_bin = 1'b0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    logic signed [31:0]             o_out_value;
    logic                           o_out_last;
    logic                           i_cfg_we = 1'b0;
    logic [sgrm_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [sgrm_pkg::CFG_W-1:0]     i_cfg_wdata = '0;

    spectral_gain_residual_mixer_core dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic        cf_enable, cf_listen;
    logic [16:0] cf_wamt, cf_red, cf_srate;
    logic [15:0] cf_decay;
    int          peak_mem [sgrm_pkg::HALF_BINS];
    int          proc_mem [sgrm_pkg::HALF_BINS];
    longint      wet_mix;
    int          bin_pos;
    bit          white_on;

    sgrm_pkg::t_item bins_pending [$];
    t_out_bin        bins_due [$];
    int              errors = 0;
    int              bins_seen = 0;

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint rnd16(longint p);
        return (p + 32768) >>> 16;
    endfunction

    function automatic longint unit_clamp(logic [16:0] v);
        return (v > 17'd65536) ? 64'd65536 : longint'(v);
    endfunction

    // processes one accepted request and queues the bin it should produce
    function automatic void mix_bin(logic signed [31:0] bv, logic [16:0] g,
                                    logic act, logic lst);
        longint b, gain, wamt, red, den, res, pk, dec, white, fin, result, tgt;
        int k;
        t_out_bin o;
        b = longint'(bv);
        gain = unit_clamp(g);
        wamt = unit_clamp(cf_wamt);
        red = unit_clamp(cf_red);
        k = bin_pos;
        if (k == 0) begin
            tgt = cf_enable ? 64'd65536 : 64'd0;
            wet_mix += rnd16((tgt - wet_mix) * unit_clamp(cf_srate));
        end
        if (act) begin
            den = sat32(rnd16(b * gain));
            res = sat32(b - den);
            if (wamt > 0) begin
                pk = (res > sgrm_pkg::PEAK_FLOOR) ? res : sgrm_pkg::PEAK_FLOOR;
                if (white_on) begin
                    dec = sat32(rnd16(longint'(peak_mem[k]) * longint'(cf_decay)));
                    if (dec > pk)
                        pk = dec;
                end
                peak_mem[k] = int'(pk);
                if (res > 0) begin
                    white = (res * 65536 + pk / 2) / pk;
                    res = sat32(rnd16((sgrm_pkg::Q_ONE - wamt) * res + wamt * white));
                end
            end
            fin = cf_listen ? res : sat32(den + rnd16(res * red));
            proc_mem[k] = int'(fin);
        end
        result = sat32(rnd16((sgrm_pkg::Q_ONE - wet_mix) * b
                             + wet_mix * longint'(proc_mem[k])));
        proc_mem[k] = int'(result);
        if (lst || k == sgrm_pkg::HALF_BINS - 1) begin
            if (act && wamt > 0)
                white_on = 1'b1;
            bin_pos = 0;
        end else begin
            bin_pos = k + 1;
        end
        o.value = result[31:0];
        o.last = lst;
        bins_due.push_back(o);
    endfunction

    // request driver: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        logic nv;
        sgrm_pkg::t_item it;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            nv = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                mix_bin(i_bin_value, i_bin_gain, i_frame_active, i_last_bin);
                nv = 1'b0;
            end
            if (!nv) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (bins_pending.size() > 0) begin
                    it = bins_pending.pop_front();
                    i_bin_value <= it.bin;
                    i_bin_gain <= it.gain;
                    i_frame_active <= it.active;
                    i_last_bin <= it.last;
                    nv = 1'b1;
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 24);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            i_in_valid <= nv;
        end
    end

    // output monitor with its own stall pattern and one long hold-off
    int  stall_pct = 0;
    int  pattern_left = 0;
    int  hold_left = 0;
    bit  held_once = 0;
    always @(posedge i_clk) begin
        t_out_bin e;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                bins_seen++;
                if (bins_due.size() == 0) begin
                    $error("unexpected output bin value=%0d last=%0b", o_out_value, o_out_last);
                    errors++;
                end else begin
                    e = bins_due.pop_front();
                    if (o_out_value !== e.value) begin
                        $error("out_value expected %0d actual %0d", e.value, o_out_value);
                        errors++;
                    end
                    if (o_out_last !== e.last) begin
                        $error("out_last expected %0b actual %0b", e.last, o_out_last);
                        errors++;
                    end
                end
            end
            if (!held_once && bins_seen == 120) begin
                held_once = 1;
                hold_left = 400;
            end
            if (pattern_left == 0) begin
                pattern_left = $urandom_range(10, 80);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            pattern_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    task automatic write_cfg(logic [sgrm_pkg::CFG_IDX_W-1:0] idx,
                             logic [sgrm_pkg::CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        case (idx)
            sgrm_pkg::CFG_ENABLE:     cf_enable = val[0];
            sgrm_pkg::CFG_RES_ONLY:   cf_listen = val[0];
            sgrm_pkg::CFG_WHITENING:  cf_wamt = val;
            sgrm_pkg::CFG_REDUCTION:  cf_red = val;
            sgrm_pkg::CFG_PEAK_DECAY: cf_decay = val[15:0];
            sgrm_pkg::CFG_SMOOTHING:  cf_srate = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        wait (bins_pending.size() == 0 && !i_in_valid && bins_due.size() == 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic add_bin(logic signed [31:0] v, logic [16:0] g, logic act, logic lst);
        sgrm_pkg::t_item it;
        it.bin = v;
        it.gain = g;
        it.active = act;
        it.last = lst;
        bins_pending.push_back(it);
    endtask

    function automatic logic signed [31:0] rand_bin();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $signed($urandom_range(0, 4000)) - 2000;
            2: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            3: return $urandom_range(0, 1) ? 32'sh7FFFFFFF - $urandom_range(0, 9)
                                           : 32'sh80000000 + $urandom_range(0, 9);
            default: return $signed($urandom_range(0, 1 << 26)) - (1 << 25);
        endcase
    endfunction

    task automatic add_frames(int n_bins);
        int len, i;
        logic act;
        while (n_bins > 0) begin
            len = $urandom_range(1, 16);
            act = ($urandom_range(0, 5) != 0);
            for (i = 0; i < len && n_bins > 0; i++) begin
                add_bin(rand_bin(),
                        ($urandom_range(0, 7) == 0) ? 17'($urandom_range(0, 131071))
                                                    : 17'($urandom_range(0, 65536)),
                        ($urandom_range(0, 15) == 0) ? !act : act,
                        (i == len - 1) || ($urandom_range(0, 40) == 0));
                n_bins--;
            end
        end
    endtask

    initial begin
        cf_enable = 0; cf_listen = 0; cf_wamt = 0; cf_red = 17'd65536;
        cf_decay = 16'd65000; cf_srate = 17'd2048;
        wet_mix = 0; bin_pos = 0; white_on = 0;
        foreach (peak_mem[i]) begin
            peak_mem[i] = 0;
            proc_mem[i] = 0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fully wet at once, maximum whitening
        write_cfg(sgrm_pkg::CFG_ENABLE, 17'd1);
        write_cfg(sgrm_pkg::CFG_SMOOTHING, 17'd65536);
        write_cfg(sgrm_pkg::CFG_WHITENING, 17'd65536);
        write_cfg(sgrm_pkg::CFG_REDUCTION, 17'd32768);
        write_cfg(sgrm_pkg::CFG_PEAK_DECAY, 17'd65535);
        write_cfg(sgrm_pkg::CFG_RES_ONLY, 17'd0);
        write_cfg(CFG_IDX_UNUSED, 17'h1FFFF);
        // first whitened frame: extremes, gain limits, inactive bin
        add_bin(32'sd0, 17'd0, 1, 0);
        add_bin(32'sh7FFFFFFF, 17'd0, 1, 0);
        add_bin(32'sh80000000, 17'd0, 1, 0);
        add_bin(32'sh7FFFFFFF, 17'd65536, 1, 0);
        add_bin(-32'sd1, 17'd131071, 1, 0);
        add_bin(32'sd1311, 17'd0, 0, 0);
        add_bin(32'sd1000, 17'd0, 1, 0);
        add_bin(-32'sd70000, 17'd30000, 1, 1);
        // second frame: decayed peaks in play
        add_bin(32'sd500, 17'd0, 1, 0);
        add_bin(32'sh7FFFFFFF, 17'd0, 1, 0);
        add_bin(32'sh80000000, 17'd65535, 1, 0);
        add_bin(32'sd65536, 17'd32768, 1, 0);
        add_bin(-32'sd5, 17'd1, 1, 0);
        add_bin(32'sd1312, 17'd0, 1, 0);
        add_bin(32'sd12345678, 17'd100000, 1, 1);
        // inactive frame reuses stored bins
        add_bin(32'sd0, 17'd0, 0, 0);
        add_bin(32'sd77, 17'd5, 0, 0);
        add_bin(-32'sd99, 17'd65536, 0, 1);
        add_frames(60);
        wait_idle();

        // residual only, out-of-range coefficients, no decay, frozen mix
        write_cfg(sgrm_pkg::CFG_RES_ONLY, 17'd1);
        write_cfg(sgrm_pkg::CFG_WHITENING, 17'h1FFFF);
        write_cfg(sgrm_pkg::CFG_REDUCTION, 17'h1FFFF);
        write_cfg(sgrm_pkg::CFG_PEAK_DECAY, 17'd0);
        write_cfg(sgrm_pkg::CFG_SMOOTHING, 17'd0);
        add_frames(90);
        wait_idle();

        // fade toward dry, whitening off
        write_cfg(sgrm_pkg::CFG_ENABLE, 17'd0);
        write_cfg(sgrm_pkg::CFG_SMOOTHING, 17'd20000);
        write_cfg(sgrm_pkg::CFG_WHITENING, 17'd0);
        write_cfg(sgrm_pkg::CFG_REDUCTION, 17'd0);
        write_cfg(sgrm_pkg::CFG_RES_ONLY, 17'd0);
        add_frames(90);
        wait_idle();

        // default-like settings, then one frame that runs past HALF_BINS
        write_cfg(sgrm_pkg::CFG_ENABLE, 17'd1);
        write_cfg(sgrm_pkg::CFG_SMOOTHING, 17'd2048);
        write_cfg(sgrm_pkg::CFG_WHITENING, 17'd30000);
        write_cfg(sgrm_pkg::CFG_PEAK_DECAY, 17'd65000);
        write_cfg(sgrm_pkg::CFG_REDUCTION, 17'd65536);
        add_frames(60);
        for (int i = 0; i < sgrm_pkg::HALF_BINS + 6; i++)
            add_bin(rand_bin(), 17'($urandom_range(0, 65536)), 1, 0);
        add_bin(rand_bin(), 17'($urandom_range(0, 65536)), 1, 1);
        wait_idle();

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
